FILE: rtl/mjp_pkg.sv
// ----------------------------------------------------------------------------
// mjp_pkg
// Shared widths, fixed-point constants and the pipeline tag for the
// minimum-jerk interpolator.
// ----------------------------------------------------------------------------
package mjp_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int S_W        = FRAC_BITS + 1;   // Q0.24 fraction, 1.0 included
   localparam int H_W        = FRAC_BITS + 5;   // signed Horner accumulator
   localparam int POS_W      = 32;
   localparam int DIFF_W     = POS_W + 1;
   localparam int SPAN_W     = 13;
   localparam int DIV_BITS   = 4;               // quotient bits per divider stage
   localparam int DIV_STAGES = (S_W - 1) / DIV_BITS;
   localparam int HORNER_STEPS = 4;

   localparam int ONE_INT = 1 << FRAC_BITS;
   localparam logic signed [H_W-1:0] ONE_H      = H_W'(ONE_INT);
   localparam logic signed [H_W-1:0] H_MINUS_15 = H_W'(-15 * ONE_INT);
   localparam logic signed [H_W-1:0] H_TEN      = H_W'(10 * ONE_INT);

   typedef struct packed {
      logic                     valid;
      logic                     invalid;
      logic signed [POS_W-1:0]  start_pos;
      logic signed [DIFF_W-1:0] diff;
   } tag_type;

endpackage

FILE: rtl/mjp_div_stage.sv
// ----------------------------------------------------------------------------
// mjp_div_stage
// One registered stage of the restoring divider that forms step / span as a
// Q0.24 fraction, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module mjp_div_stage #(
   parameter int DIV_W = 13
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mjp_pkg::tag_type         tag_in,
   input  logic [DIV_W-1:0]         rem_in,
   input  logic [DIV_W-1:0]         den_in,
   input  logic [mjp_pkg::S_W-1:0]  quo_in,
   output mjp_pkg::tag_type         tag_out,
   output logic [DIV_W-1:0]         rem_out,
   output logic [DIV_W-1:0]         den_out,
   output logic [mjp_pkg::S_W-1:0]  quo_out
);
   import mjp_pkg::*;

   tag_type          tag_ff;
   logic [DIV_W-1:0] rem_ff, rem_in_v;
   logic [DIV_W-1:0] den_ff;
   logic [S_W-1:0]   quo_ff, quo_in_v;
   logic [DIV_W+1:0] trial;

   always_comb begin
      rem_in_v = rem_in;
      quo_in_v = quo_in;
      trial    = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         // remainder stays below the divisor, so twice it fits when it loses
         trial = {1'b0, rem_in_v, 1'b0} - {2'b00, den_in};
         if (!trial[DIV_W+1]) begin
            rem_in_v = trial[DIV_W-1:0];
         end else begin
            rem_in_v = {rem_in_v[DIV_W-2:0], 1'b0};
         end
         quo_in_v = {quo_in_v[S_W-2:0], ~trial[DIV_W+1]};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      rem_ff <= rem_in_v;
      den_ff <= den_in;
      quo_ff <= quo_in_v;
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end
   end

   assign tag_out = tag_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      tag_ff.valid && !tag_ff.invalid |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

endmodule

FILE: rtl/mjp_horner_step.sv
// ----------------------------------------------------------------------------
// mjp_horner_step
// One Horner step of the blend polynomial: h' = floor(h * s) + c, with a
// register after the multiply and one after the floor and add.
// ----------------------------------------------------------------------------
module mjp_horner_step #(
   parameter logic signed [mjp_pkg::H_W-1:0] ADD_CONST = '0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mjp_pkg::tag_type                tag_in,
   input  logic signed [mjp_pkg::H_W-1:0]  h_in,
   input  logic [mjp_pkg::S_W-1:0]         s_in,
   output mjp_pkg::tag_type                tag_out,
   output logic signed [mjp_pkg::H_W-1:0]  h_out,
   output logic [mjp_pkg::S_W-1:0]         s_out
);
   import mjp_pkg::*;

   localparam int PROD_W = H_W + S_W + 1;

   tag_type                  tag_a_ff, tag_b_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [S_W-1:0]           s_a_ff, s_b_ff;
   logic signed [H_W-1:0]    h_ff, h_in_v;

   assign prod_in = h_in * $signed({1'b0, s_in});
   // arithmetic shift floors toward minus infinity
   assign h_in_v  = H_W'(prod_ff >>> FRAC_BITS) + ADD_CONST;

   always_ff @(posedge clock) begin
      tag_a_ff <= tag_in;
      prod_ff  <= prod_in;
      s_a_ff   <= s_in;
      tag_b_ff <= tag_a_ff;
      h_ff     <= h_in_v;
      s_b_ff   <= s_a_ff;
      if (reset) begin
         tag_a_ff.valid <= 1'b0;
         tag_b_ff.valid <= 1'b0;
      end
   end

   assign tag_out = tag_b_ff;
   assign h_out   = h_ff;
   assign s_out   = s_b_ff;

endmodule

FILE: rtl/mjp_blend.sv
// ----------------------------------------------------------------------------
// mjp_blend
// Clamps the blend factor, scales the position difference by it and adds
// the start position with saturation; drives the result registers.
// ----------------------------------------------------------------------------
module mjp_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  mjp_pkg::tag_type                  tag_in,
   input  logic signed [mjp_pkg::H_W-1:0]    h_in,
   output logic                              rsp_strobe,
   output logic signed [mjp_pkg::POS_W-1:0]  rsp_position,
   output logic                              rsp_invalid
);
   import mjp_pkg::*;

   localparam int PROD_W = DIFF_W + S_W + 1;
   localparam int SUM_W  = DIFF_W + 1;
   localparam logic signed [SUM_W-1:0] POS_MAX =
      {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] POS_MIN =
      {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

   tag_type                  tag1_ff, tag2_ff, tag3_ff;
   logic [S_W-1:0]           hc_ff, hc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0]  sum_v;
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic signed [SUM_W-1:0]  move_chk;

   always_comb begin
      if (h_in < 0) begin
         hc_in = '0;
      end else if (h_in > ONE_H) begin
         hc_in = ONE_H[S_W-1:0];
      end else begin
         hc_in = h_in[S_W-1:0];
      end
   end

   assign prod_in = tag1_ff.diff * $signed({1'b0, hc_ff});
   assign sum_v   = SUM_W'(tag2_ff.start_pos) + SUM_W'(prod_ff >>> FRAC_BITS);

   always_comb begin
      if (tag2_ff.invalid) begin
         pos_in = tag2_ff.start_pos;
      end else if (sum_v > POS_MAX) begin
         pos_in = POS_MAX[POS_W-1:0];
      end else if (sum_v < POS_MIN) begin
         pos_in = POS_MIN[POS_W-1:0];
      end else begin
         pos_in = sum_v[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= tag_in;
      hc_ff   <= hc_in;
      tag2_ff <= tag1_ff;
      prod_ff <= prod_in;
      tag3_ff <= tag2_ff;
      pos_ff  <= pos_in;
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end
   end

   assign rsp_strobe   = tag3_ff.valid;
   assign rsp_position = pos_ff;
   assign rsp_invalid  = tag3_ff.invalid;

   // distance moved from the start position
   assign move_chk = SUM_W'(pos_ff) - SUM_W'(tag3_ff.start_pos);

   a_between_ends: assert property (@(posedge clock) disable iff (reset)
      tag3_ff.valid && !tag3_ff.invalid |->
         ((tag3_ff.diff >= 0) && (move_chk >= 0) && (move_chk <= tag3_ff.diff)) ||
         ((tag3_ff.diff < 0) && (move_chk <= 0) && (move_chk >= tag3_ff.diff)))
      else $error("position outside the segment end points");

   a_invalid_holds_start: assert property (@(posedge clock) disable iff (reset)
      tag3_ff.valid && tag3_ff.invalid |-> move_chk == 0)
      else $error("invalid item moved off its start position");

endmodule

FILE: rtl/min_jerk_interpolator.sv
// ----------------------------------------------------------------------------
// min_jerk_interpolator
// Minimum-jerk quintic interpolation of one joint position per item:
// x0 + (x1 - x0) * (10s^3 - 15s^4 + 6s^5), s = step / span in Q0.24.
// ----------------------------------------------------------------------------
// pipeline stages from the accepting edge to the edge that takes the result
//   (1 input stage, 6 divider stages, 1 stage for 6s - 15, 4 Horner steps of
//   2 stages each, 3 stages of clamp, scale and saturating add)
// throughput: one item per cycle, set by the fully pipelined divider and
//   multipliers; results leave as soon as they are done, the receiver cannot stall
// reset: synchronous; clears every stage's valid bit, busy is high while reset is
module min_jerk_interpolator #(
   parameter int MAX_SPAN = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [mjp_pkg::POS_W-1:0]  req_start_pos,
   input  logic signed [mjp_pkg::POS_W-1:0]  req_end_pos,
   input  logic [mjp_pkg::SPAN_W-1:0]        req_span,
   input  logic [mjp_pkg::SPAN_W-1:0]        req_step,
   output logic                              rsp_strobe,
   output logic signed [mjp_pkg::POS_W-1:0]  rsp_position,
   output logic                              rsp_invalid
);
   import mjp_pkg::*;

   localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);
   localparam int DIV_W     = (SPAN_BITS < SPAN_W) ? SPAN_BITS : SPAN_W;
   localparam int LATENCY   = 1 + DIV_STAGES + 1 + 2 * HORNER_STEPS + 3;

   logic    accept;
   logic    step_ge_span;
   tag_type in_tag;

   tag_type          div_tag [DIV_STAGES+1];
   logic [DIV_W-1:0] div_rem [DIV_STAGES+1];
   logic [DIV_W-1:0] div_den [DIV_STAGES+1];
   logic [S_W-1:0]   div_quo [DIV_STAGES+1];

   tag_type               h1_tag_ff;
   logic signed [H_W-1:0] h1_ff, h1_in;
   logic [S_W-1:0]        h1_s_ff;

   tag_type               hn_tag [HORNER_STEPS+1];
   logic signed [H_W-1:0] hn_h   [HORNER_STEPS+1];
   logic [S_W-1:0]        hn_s   [HORNER_STEPS];

   assign busy   = reset;
   assign accept = start && !busy;

   // input stage: range check, difference, top quotient bit
   assign step_ge_span     = req_step >= req_span;
   assign in_tag.valid     = accept;
   assign in_tag.invalid   = (req_span == '0) || (req_step > req_span) ||
                             (int'(req_span) > MAX_SPAN);
   assign in_tag.start_pos = req_start_pos;
   assign in_tag.diff      = DIFF_W'(req_end_pos) - DIFF_W'(req_start_pos);

   tag_type          tag0_ff;
   logic [DIV_W-1:0] rem0_ff, den0_ff;
   logic [S_W-1:0]   quo0_ff;

   always_ff @(posedge clock) begin
      tag0_ff <= in_tag;
      rem0_ff <= step_ge_span ? '0 : req_step[DIV_W-1:0];
      den0_ff <= req_span[DIV_W-1:0];
      quo0_ff <= S_W'(step_ge_span);
      if (reset) begin
         tag0_ff.valid <= 1'b0;
      end
   end

   assign div_tag[0] = tag0_ff;
   assign div_rem[0] = rem0_ff;
   assign div_den[0] = den0_ff;
   assign div_quo[0] = quo0_ff;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      mjp_div_stage #(
         .DIV_W (DIV_W)
      ) u_div (
         .clock   (clock),
         .reset   (reset),
         .tag_in  (div_tag[k]),
         .rem_in  (div_rem[k]),
         .den_in  (div_den[k]),
         .quo_in  (div_quo[k]),
         .tag_out (div_tag[k+1]),
         .rem_out (div_rem[k+1]),
         .den_out (div_den[k+1]),
         .quo_out (div_quo[k+1])
      );
   end

   // first Horner step needs no multiplier: 6s - 15
   assign h1_in = H_W'({div_quo[DIV_STAGES], 2'b00}) + H_W'({div_quo[DIV_STAGES], 1'b0}) +
                  H_MINUS_15;

   always_ff @(posedge clock) begin
      h1_tag_ff <= div_tag[DIV_STAGES];
      h1_ff     <= h1_in;
      h1_s_ff   <= div_quo[DIV_STAGES];
      if (reset) begin
         h1_tag_ff.valid <= 1'b0;
      end
   end

   assign hn_tag[0] = h1_tag_ff;
   assign hn_h[0]   = h1_ff;
   assign hn_s[0]   = h1_s_ff;

   for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
      if (k < HORNER_STEPS - 1) begin : g_mid
         mjp_horner_step #(
            .ADD_CONST ((k == 0) ? H_TEN : '0)
         ) u_step (
            .clock   (clock),
            .reset   (reset),
            .tag_in  (hn_tag[k]),
            .h_in    (hn_h[k]),
            .s_in    (hn_s[k]),
            .tag_out (hn_tag[k+1]),
            .h_out   (hn_h[k+1]),
            .s_out   (hn_s[k+1])
         );
      end else begin : g_last
         mjp_horner_step #(
            .ADD_CONST ('0)
         ) u_step (
            .clock   (clock),
            .reset   (reset),
            .tag_in  (hn_tag[k]),
            .h_in    (hn_h[k]),
            .s_in    (hn_s[k]),
            .tag_out (hn_tag[k+1]),
            .h_out   (hn_h[k+1]),
            .s_out   ()
         );
      end
   end

   mjp_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .tag_in       (hn_tag[HORNER_STEPS]),
      .h_in         (hn_h[HORNER_STEPS]),
      .rsp_strobe   (rsp_strobe),
      .rsp_position (rsp_position),
      .rsp_invalid  (rsp_invalid)
   );

   a_item_comes_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted item produced no result");

   a_no_extra_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching item");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks each result of the minimum-jerk interpolator, in order, against a
// behavioral predictor of the quintic blend. Covers the segment ends, the
// invalid spans and steps, and random well-formed segments and noise, with
// and without random sender gaps.
// ----------------------------------------------------------------------------
module tb;
   import mjp_pkg::*;

   localparam int MAX_SPAN    = 4096;
   localparam int PIPE_DEPTH  = 19;
   localparam int STALL_LIMIT = 1000;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic                    invalid;
   } joint_point_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [POS_W-1:0]  req_start_pos;
   logic signed [POS_W-1:0]  req_end_pos;
   logic [SPAN_W-1:0]        req_span;
   logic [SPAN_W-1:0]        req_step;
   logic                     rsp_strobe;
   logic signed [POS_W-1:0]  rsp_position;
   logic                     rsp_invalid;

   joint_point_type pending_points[$];
   int              mismatches;
   int              stall_cycles;
   bit              gaps_on;

   min_jerk_interpolator #(
      .MAX_SPAN(MAX_SPAN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_start_pos(req_start_pos),
      .req_end_pos(req_end_pos),
      .req_span(req_span),
      .req_step(req_step),
      .rsp_strobe(rsp_strobe),
      .rsp_position(rsp_position),
      .rsp_invalid(rsp_invalid)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_start_pos = '0;
      req_end_pos = '0;
      req_span = '0;
      req_step = '0;
   end

   always #5 clock = ~clock;

   // quintic blend in Q8.24, every product floored back to Q.24
   function automatic joint_point_type quintic_point(input logic signed [POS_W-1:0] x0,
                                                     input logic signed [POS_W-1:0] x1,
                                                     input logic [SPAN_W-1:0] span,
                                                     input logic [SPAN_W-1:0] step);
      joint_point_type pt;
      longint signed frac, blend, diff, pos;
      longint signed unit;
      unit = longint'(1) <<< FRAC_BITS;
      pt.invalid = 1'b0;
      if (span == 0 || step > span || span > MAX_SPAN) begin
         pt.position = x0;
         pt.invalid = 1'b1;
         return pt;
      end
      frac = (longint'(step) <<< FRAC_BITS) / longint'(span);
      blend = 6 * unit;
      blend = ((blend * frac) >>> FRAC_BITS) - 15 * unit;
      blend = ((blend * frac) >>> FRAC_BITS) + 10 * unit;
      repeat (3) blend = (blend * frac) >>> FRAC_BITS;
      if (blend < 0) blend = 0;
      if (blend > unit) blend = unit;
      diff = longint'(x1) - longint'(x0);
      pos = longint'(x0) + ((diff * blend) >>> FRAC_BITS);
      if (pos > 64'sd2147483647) pos = 64'sd2147483647;
      if (pos < -64'sd2147483648) pos = -64'sd2147483648;
      pt.position = pos[POS_W-1:0];
      return pt;
   endfunction

   function automatic logic signed [POS_W-1:0] rand_pos();
      logic signed [POS_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = 32'sh8000_0000;
         1: v = 32'sh7fff_ffff;
         2: v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic send_item(input logic signed [POS_W-1:0] x0,
                            input logic signed [POS_W-1:0] x1,
                            input logic [SPAN_W-1:0] span,
                            input logic [SPAN_W-1:0] step);
      req_start_pos <= x0;
      req_end_pos <= x1;
      req_span <= span;
      req_step <= step;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_points.push_back(quintic_point(x0, x1, span, step));
   endtask

   task automatic sender_gap();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   task automatic test_directed();
      send_item(32'sh8000_0000, 32'sh7fff_ffff, 13'd100, 13'd0);
      send_item(32'sh8000_0000, 32'sh7fff_ffff, 13'd100, 13'd100);
      send_item(32'sh7fff_ffff, 32'sh8000_0000, 13'd100, 13'd50);
      send_item(32'sh8000_0000, 32'sh7fff_ffff, 13'd4096, 13'd2048);
      send_item(32'sh7fff_ffff, 32'sh8000_0000, 13'd4096, 13'd1);
      send_item(32'sh7fff_ffff, 32'sh8000_0000, 13'd4096, 13'd4095);
      send_item(32'sh0001_0000, 32'sh0005_0000, 13'd4096, 13'd4096);
      // zero span and step past the end
      send_item(32'sh1234_5678, 32'sh0000_0000, 13'd0, 13'd0);
      send_item(32'sh1234_5678, 32'sh0000_0000, 13'd0, 13'd5);
      send_item(-32'sh0002_0000, 32'sh0000_0000, 13'd10, 13'd11);
      send_item(32'sh0000_0000, 32'sh0001_0000, 13'd1, 13'd8191);
      // spans the divider cannot take
      send_item(32'sh0003_0000, 32'sh0009_0000, 13'd4097, 13'd1000);
      send_item(32'sh0003_0000, 32'sh0009_0000, 13'd8191, 13'd8191);
      send_item(32'sh0003_0000, 32'sh0009_0000, 13'd8191, 13'd0);
      send_item(32'sh0000_0000, 32'sh0001_0000, 13'd1, 13'd0);
      send_item(32'sh0000_0000, 32'sh0001_0000, 13'd1, 13'd1);
      send_item(32'sh0000_0000, 32'sh0001_0000, 13'd3, 13'd1);
      send_item(32'sh0000_0000, 32'sh0001_0000, 13'd3, 13'd2);
      send_item(32'sh0000_0000, -32'sh0001_0000, 13'd7, 13'd3);
      send_item(32'sh5555_5555, 32'sh5555_5555, 13'd2, 13'd1);
      send_item(-32'sh0000_0001, 32'sh0000_0001, 13'd4096, 13'd4000);
   endtask

   task automatic test_segments(input int count);
      logic [SPAN_W-1:0] span, step;
      for (int i = 0; i < count; i++) begin
         span = ($urandom_range(0, 3) == 0) ? SPAN_W'($urandom_range(1, 16)) :
                                              SPAN_W'($urandom_range(1, MAX_SPAN));
         case ($urandom_range(0, 9))
            0: step = '0;
            1: step = span;
            default: step = SPAN_W'($urandom_range(0, span));
         endcase
         send_item(rand_pos(), rand_pos(), span, step);
         sender_gap();
      end
   endtask

   task automatic test_noise(input int count);
      for (int i = 0; i < count; i++) begin
         send_item(rand_pos(), rand_pos(), SPAN_W'($urandom_range(0, 8191)),
                   SPAN_W'($urandom_range(0, 8191)));
         sender_gap();
      end
   endtask

   // result checker: the receiver cannot stall, so each strobe is one result
   always @(posedge clock) begin
      joint_point_type want;
      if (!reset && rsp_strobe) begin
         if (pending_points.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: position %0d invalid %0b", rsp_position,
                        rsp_invalid);
            mismatches++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_position !== want.position || rsp_invalid !== want.invalid) begin
               if (mismatches < 10)
                  $display("mismatch: position exp %0d got %0d, invalid exp %0b got %0b",
                           want.position, rsp_position, want.invalid, rsp_invalid);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving either way
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      mismatches = 0;
      stall_cycles = 0;
      gaps_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_segments(700);
      wait_drained();
      test_noise(250);
      test_segments(150);
      gaps_on = 1'b0;
      test_segments(200);
      test_noise(50);
      wait_drained();
      repeat (PIPE_DEPTH + 6) @(posedge clock);
      if (pending_points.size() != 0) begin
         $display("%0d results never arrived", pending_points.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
